// ----- rtl/lzss_pkg.sv -----
// ----------------------------------------------------------------------------
// lzss_pkg: shared types and codes of the LZSS flag-byte decompressor
// Payload structs, result kinds, parse phases, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lzss_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 24;
    localparam int OFF_W     = 14;
    localparam int LEN_W     = 6;
    localparam int ITEMS_W   = 4;
    localparam int PH_W      = 2;
    localparam int LIT_W     = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 24;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

    // Parse phases
    localparam logic [PH_W-1:0] PH_FLAG  = 2'd0;
    localparam logic [PH_W-1:0] PH_ITEM  = 2'd1;
    localparam logic [PH_W-1:0] PH_LIT   = 2'd2;
    localparam logic [PH_W-1:0] PH_TOKHI = 2'd3;

    // Items per flag byte and bytes per triplet literal
    localparam logic [ITEMS_W-1:0] ITEMS_PER_FLAG = 4'd8;
    localparam logic [LIT_W-1:0]   LIT_LAST_IDX   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_MODE = 4'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_data;
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic parse;
        logic set_src;
        logic rd;
        logic emit_lit;
        logic emit_copy;
        logic emit_end;
        logic emit_bad;
        logic last_flag;
        logic close;
        logic rearm;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic            closed;
        logic            lim_now;
        logic            lim_next;
        logic [PH_W-1:0] phase;
        logic            flag_bit;
        logic            last_in;
        logic            bad_ref;
        logic            count_one;
        logic            out_free;
    } t_stat;

endpackage

// ----- rtl/lzss_flag_byte_decompressor_unit.sv -----
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor_unit: LZSS flag-byte decompressor
// Decodes a compressed byte stream (flag byte plus eight literal or
// back-reference items) into data bytes with end and error results.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in)
//   out     | output    | o_out_valid / i_out_ready| o_out_data (t_out)
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One input transaction at a time: flag and token-low bytes pass IDLE, PRE and
// TAIL; literal bytes add LIT, a back reference adds CHECK plus RD and CP per copied byte
// (history RAM read with registered data, then write of the copied byte).
// A limit or error result adds an END or BAD state; the end result of a final byte
// is issued in the closing TAIL state and adds none.
// Reset is synchronous; the history window needs no clearing pass.
// A stalled output holds its result register and the controller waits.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decompressor_unit
    import lzss_pkg::*;
#(
    parameter int WINDOW_BYTES = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    lzss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lzss_dp #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ----- rtl/lzss_ram.sv -----
// ----------------------------------------------------------------------------
// lzss_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lzss_dp.sv -----
// ----------------------------------------------------------------------------
// lzss_dp: datapath of the LZSS decompressor
// Holds configuration, parse state, counters, history window and the
// output register; acts on controller commands and reports status.
// ----------------------------------------------------------------------------
module lzss_dp
    import lzss_pkg::*;
#(
    parameter int WINDOW_BYTES = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  t_in                  i_in_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int SW = (AW > OFF_W) ? AW : OFF_W;
    localparam int XW = SW + 1;

    // Configuration
    logic [CNT_W-1:0] r_out_limit;
    logic             r_unit_mode;

    // Latched input transaction
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    // Parse and copy state
    logic [PH_W-1:0]    r_phase,  n_phase;
    logic [ITEMS_W-1:0] r_items,  n_items;
    logic [BYTE_W-1:0]  r_flags,  n_flags;
    logic [LIT_W-1:0]   r_lit,    n_lit;
    logic [BYTE_W-1:0]  r_tok,    n_tok;
    logic               r_closed, n_closed;
    logic [AW-1:0]      r_wp,     n_wp;
    logic [CNT_W-1:0]   r_prod,   n_prod;
    logic [OFF_W-1:0]   r_offset, n_offset;
    logic [LEN_W-1:0]   r_count,  n_count;
    logic [AW-1:0]      r_src,    n_src;

    // Output register
    logic r_ovalid;
    t_out r_out;

    logic [PH_W-1:0]   ph_eff;
    logic              flag_bit;
    logic [11:0]       off12;
    logic [OFF_W-1:0]  tok_offset;
    logic [LEN_W-1:0]  tok_len;
    logic [LEN_W-1:0]  len_units;
    logic [ITEMS_W-1:0] items_inc;
    logic [PH_W-1:0]   ph_after;
    logic [PH_W-1:0]   ph_after_inc;
    logic [XW-1:0]     wp_x;
    logic [XW-1:0]     off_x;
    logic [AW-1:0]     src_calc;
    logic [AW-1:0]     src_inc;
    logic [AW-1:0]     wp_inc;
    logic              bad_ref;
    logic              emit_data;
    logic              emit_any;
    logic              out_free;
    logic [BYTE_W-1:0] hist_rdata;
    logic [BYTE_W-1:0] wr_byte;
    logic [CNT_W-1:0]  prod_inc;

    // Pass over a spent flag byte
    assign ph_eff   = (r_phase == PH_ITEM && r_items >= ITEMS_PER_FLAG) ? PH_FLAG : r_phase;
    assign flag_bit = r_flags[r_items[2:0]];

    // Decode the back-reference token from the high byte and the stored low byte
    assign off12     = {r_byte, r_tok[7:4]};
    assign len_units = LEN_W'(r_tok[3:0]) + LEN_W'(1);
    assign tok_offset = r_unit_mode ? (OFF_W'({off12, 1'b0}) + OFF_W'(off12))
                                    : OFF_W'(off12);
    assign tok_len    = r_unit_mode ? (LEN_W'({len_units, 1'b0}) + len_units)
                                    : (LEN_W'(r_tok[3:0]) + LEN_W'(2));

    assign items_inc    = r_items + ITEMS_W'(1);
    assign ph_after     = (r_items >= ITEMS_PER_FLAG) ? PH_FLAG : PH_ITEM;
    assign ph_after_inc = (items_inc >= ITEMS_PER_FLAG) ? PH_FLAG : PH_ITEM;

    // Check the reference against produced data and the window
    assign bad_ref = (r_offset == '0)
                   || (CNT_W'(r_offset) > r_prod)
                   || (32'(r_offset) > 32'(WINDOW_BYTES));

    // Source address: write position minus offset, modulo the window
    assign wp_x     = XW'(r_wp);
    assign off_x    = XW'(r_offset);
    assign src_calc = (wp_x >= off_x) ? AW'(wp_x - off_x)
                                      : AW'(wp_x + XW'(WINDOW_BYTES) - off_x);
    assign src_inc  = (r_src == AW'(WINDOW_BYTES - 1)) ? '0 : r_src + AW'(1);
    assign wp_inc   = (r_wp == AW'(WINDOW_BYTES - 1)) ? '0 : r_wp + AW'(1);
    assign prod_inc = r_prod + CNT_W'(1);

    assign emit_data = i_cmd.emit_lit | i_cmd.emit_copy;
    assign emit_any  = emit_data | i_cmd.emit_end | i_cmd.emit_bad;
    assign out_free  = !r_ovalid || i_out_ready;
    assign wr_byte   = i_cmd.emit_lit ? r_byte : hist_rdata;

    // History window
    lzss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (emit_data),
        .i_waddr (r_wp),
        .i_wdata (wr_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_src),
        .o_rdata (hist_rdata)
    );

    // Next parse and copy state
    always_comb begin
        n_phase  = r_phase;
        n_items  = r_items;
        n_flags  = r_flags;
        n_lit    = r_lit;
        n_tok    = r_tok;
        n_closed = r_closed;
        n_wp     = r_wp;
        n_prod   = r_prod;
        n_offset = r_offset;
        n_count  = r_count;
        n_src    = r_src;
        if (i_cmd.parse) begin
            unique case (ph_eff)
                PH_ITEM: begin
                    n_items = items_inc;
                    if (flag_bit) begin
                        if (r_unit_mode) begin
                            n_lit   = LIT_W'(1);
                            n_phase = PH_LIT;
                        end else begin
                            n_phase = ph_after_inc;
                        end
                    end else begin
                        n_tok   = r_byte;
                        n_phase = PH_TOKHI;
                    end
                end
                PH_LIT: begin
                    if (r_lit == LIT_LAST_IDX) begin
                        n_lit   = '0;
                        n_phase = ph_after;
                    end else begin
                        n_lit = r_lit + LIT_W'(1);
                    end
                end
                PH_TOKHI: begin
                    n_offset = tok_offset;
                    n_count  = tok_len;
                    n_phase  = ph_after;
                end
                PH_FLAG: begin
                    n_flags = r_byte;
                    n_items = '0;
                    n_phase = PH_ITEM;
                end
            endcase
        end
        if (i_cmd.set_src) begin
            n_src = src_calc;
        end
        if (i_cmd.rd) begin
            n_src = src_inc;
        end
        if (emit_data) begin
            n_wp   = wp_inc;
            n_prod = prod_inc;
        end
        if (i_cmd.emit_copy) begin
            n_count = r_count - LEN_W'(1);
        end
        if (i_cmd.close) begin
            n_closed = 1'b1;
        end
        // Start a new stream
        if (i_cmd.rearm) begin
            n_phase  = PH_FLAG;
            n_items  = '0;
            n_flags  = '0;
            n_lit    = '0;
            n_tok    = '0;
            n_closed = 1'b0;
            n_wp     = '0;
            n_prod   = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit <= '0;
            r_unit_mode <= 1'b0;
            r_phase     <= PH_FLAG;
            r_items     <= '0;
            r_flags     <= '0;
            r_lit       <= '0;
            r_tok       <= '0;
            r_closed    <= 1'b0;
            r_wp        <= '0;
            r_prod      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_OUT_LIMIT: r_out_limit <= i_cfg_data;
                    REG_UNIT_MODE: r_unit_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_phase  <= n_phase;
            r_items  <= n_items;
            r_flags  <= n_flags;
            r_lit    <= n_lit;
            r_tok    <= n_tok;
            r_closed <= n_closed;
            r_wp     <= n_wp;
            r_prod   <= n_prod;
            if (emit_any) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_in_data.in_byte;
            r_last <= i_in_data.in_last;
        end
        r_offset <= n_offset;
        r_count  <= n_count;
        r_src    <= n_src;
        if (emit_any) begin
            r_out.out_data <= emit_data ? wr_byte : '0;
            r_out.out_kind <= emit_data ? KIND_DATA : (i_cmd.emit_bad ? KIND_BAD : KIND_END);
            r_out.out_last <= i_cmd.last_flag;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        o_stat.closed    = r_closed;
        o_stat.lim_now   = (r_prod >= r_out_limit);
        o_stat.lim_next  = (prod_inc >= r_out_limit);
        o_stat.phase     = ph_eff;
        o_stat.flag_bit  = flag_bit;
        o_stat.last_in   = r_last;
        o_stat.bad_ref   = bad_ref;
        o_stat.count_one = (r_count == LEN_W'(1));
        o_stat.out_free  = out_free;
    end

`ifndef SYNTHESIS
    // A result is only loaded when the output register has room
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_any |-> out_free)
        else $error("result loaded into a busy output register");

    // No data byte leaves a closed stream
    a_no_data_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_data |-> !r_closed)
        else $error("data byte emitted on a closed stream");

    // A copy never runs past its length
    a_copy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_copy |-> (r_count != '0))
        else $error("copy byte emitted with no length left");

    // A new stream starts empty and open
    a_rearm_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rearm |=> (r_prod == '0 && !r_closed && r_phase == PH_FLAG))
        else $error("stream state not cleared after end marker");
`endif

endmodule

// ----- rtl/lzss_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzss_ctrl: controller of the LZSS decompressor
// Sequences one input transaction at a time: limit check, parse, literal
// or back-reference copy, end and error results, end-of-stream handling.
// ----------------------------------------------------------------------------
module lzss_ctrl
    import lzss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRE   = 4'd1;
    localparam logic [3:0] S_LIT   = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_CP    = 4'd5;
    localparam logic [3:0] S_END   = 4'd6;
    localparam logic [3:0] S_BAD   = 4'd7;
    localparam logic [3:0] S_TAIL  = 4'd8;

    logic [3:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PRE;
                end
            end
            S_PRE: begin
                if (!i_stat.closed && i_stat.lim_now) begin
                    n_state = S_END;
                end else if (i_stat.closed) begin
                    n_state = S_TAIL;
                end else begin
                    o_cmd.parse = 1'b1;
                    unique case (i_stat.phase)
                        PH_ITEM:  n_state = i_stat.flag_bit ? S_LIT : S_TAIL;
                        PH_LIT:   n_state = S_LIT;
                        PH_TOKHI: n_state = S_CHECK;
                        PH_FLAG:  n_state = S_TAIL;
                    endcase
                end
            end
            S_LIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_lit  = 1'b1;
                    o_cmd.last_flag = !i_stat.lim_next && !i_stat.last_in;
                    n_state         = i_stat.lim_next ? S_END : S_TAIL;
                end
            end
            S_CHECK: begin
                if (i_stat.bad_ref) begin
                    n_state = S_BAD;
                end else begin
                    o_cmd.set_src = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CP;
            end
            S_CP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_copy = 1'b1;
                    o_cmd.last_flag = i_stat.count_one && !i_stat.lim_next
                                      && !i_stat.last_in;
                    if (i_stat.lim_next) begin
                        n_state = S_END;
                    end else if (i_stat.count_one) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_end  = 1'b1;
                    o_cmd.last_flag = 1'b1;
                    o_cmd.close     = 1'b1;
                    n_state         = S_TAIL;
                end
            end
            S_BAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_bad  = 1'b1;
                    o_cmd.last_flag = 1'b1;
                    o_cmd.close     = 1'b1;
                    n_state         = S_TAIL;
                end
            end
            S_TAIL: begin
                if (!i_stat.last_in) begin
                    n_state = S_IDLE;
                end else if (i_stat.closed) begin
                    o_cmd.rearm = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_end  = 1'b1;
                    o_cmd.last_flag = 1'b1;
                    o_cmd.rearm     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // An accepted transaction is always evaluated next
    a_accept_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_PRE))
        else $error("accepted transaction not evaluated");

    // Every history read is followed by its copy emission state
    a_rd_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> (r_state == S_CP))
        else $error("history read not consumed");

    // A result is only produced with room in the output register
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_lit || o_cmd.emit_copy || o_cmd.emit_end || o_cmd.emit_bad)
        |-> i_stat.out_free)
        else $error("result issued without output room");
`endif

endmodule
